### hw/rtl/dcfd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// dcfd_pkg
// Shared widths, calendar constants and reciprocals for the day-count to
// FAT date/time converter.
// ============================================================================
package dcfd_pkg;

    // Pipeline depth: stage 0 takes the input beat, the last stage is the
    // output register.
    localparam int unsigned STAGE_CNT = 8;

    // Field widths
    localparam int unsigned DAY_W       = 16;
    localparam int unsigned MIN_W       = 11;
    localparam int unsigned TICK_W      = 12;
    localparam int unsigned WORD_W      = 16;
    localparam int unsigned IN_TDATA_W  = 40;
    localparam int unsigned OUT_TDATA_W = 32;

    // Tick rate and exact reciprocal for ticks / TICKS_PER_SEC over 12 bits
    localparam int unsigned TICKS_PER_SEC = 50;
    localparam int unsigned TICK_SHIFT    = TICK_W + $clog2(TICKS_PER_SEC);
    localparam int unsigned TICK_RECIP    =
        ((2 ** TICK_SHIFT) + TICKS_PER_SEC - 1) / TICKS_PER_SEC;
    localparam int unsigned TICK_PROD_W   = TICK_W + TICK_SHIFT + 1;

    // Time of day limits; minutes / 60 by reciprocal, exact below 1440
    localparam int unsigned MAX_MINUTE = 1439;
    localparam int unsigned MAX_SECOND = 59;
    localparam int unsigned HOUR_RECIP = 1093;
    localparam int unsigned HOUR_SHIFT = 16;

    // Calendar constants (days counted from 1 March of year 0)
    localparam int unsigned REM1_W       = 18;
    localparam int unsigned ERA_SPLIT    = 8095;     // first day count in era 5
    localparam int unsigned ERA4_OFFSET  = 138002;   // offset of 1978-01-01 in era 4
    localparam int unsigned DAYS_100Y    = 36524;
    localparam int unsigned DAYS_4Y      = 1461;
    localparam int unsigned DAYS_1Y      = 365;
    localparam int unsigned QUAD_RECIP   = 1435;     // floor(2^21 / 1461)
    localparam int unsigned QUAD_SHIFT   = 21;
    localparam int unsigned ERA4_YEAR    = 1600;
    localparam int unsigned FAT_BASE_YEAR = 1980;
    localparam int unsigned FAT_LAST_YEAR = 2107;

    localparam logic [WORD_W-1:0] DATE_LOW_LIMIT  = 16'h0021;
    localparam logic [WORD_W-1:0] DATE_HIGH_LIMIT = 16'hFF9F;

    // First day of each month in a year that starts on 1 March
    localparam logic [8:0] MARCH_MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };

endpackage

### hw/rtl/dcfd_civil.sv
`timescale 1ns / 1ps
// ============================================================================
// dcfd_civil
// Pipelined Gregorian date finder: splits the day count into 400-, 100-,
// 4- and 1-year periods, looks up the month and packs the FAT date word.
// ============================================================================
module dcfd_civil
    import dcfd_pkg::*;
(
    input  logic                 clk,
    input  logic [STAGE_CNT-1:0] stage_en,
    input  logic [DAY_W-1:0]     day_count,
    output logic [WORD_W-1:0]    packed_date,
    output logic                 range_flag
);

    // stage 0: pick the 400-year period and the day offset within it
    logic              era5_next;
    logic [REM1_W-1:0] rem1_next;
    logic              st0_era5_reg;
    logic [REM1_W-1:0] st0_rem_reg;

    always_comb
    begin
        era5_next = (day_count >= DAY_W'(ERA_SPLIT));
        if (era5_next)
        begin
            rem1_next = REM1_W'(day_count) - REM1_W'(ERA_SPLIT);
        end
        else
        begin
            rem1_next = REM1_W'(day_count) + REM1_W'(ERA4_OFFSET);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            st0_era5_reg <= era5_next;
            st0_rem_reg  <= rem1_next;
        end
    end

    // stage 1: century within the period, last day clamps to century 3
    logic [1:0]        cent_next;
    logic [REM1_W-1:0] cent_sub;
    logic              st1_era5_reg;
    logic [1:0]        st1_cent_reg;
    logic [15:0]       st1_rem_reg;

    always_comb
    begin
        priority if (st0_rem_reg >= REM1_W'(3 * DAYS_100Y))
        begin
            cent_next = 2'd3;
            cent_sub  = REM1_W'(3 * DAYS_100Y);
        end
        else if (st0_rem_reg >= REM1_W'(2 * DAYS_100Y))
        begin
            cent_next = 2'd2;
            cent_sub  = REM1_W'(2 * DAYS_100Y);
        end
        else if (st0_rem_reg >= REM1_W'(DAYS_100Y))
        begin
            cent_next = 2'd1;
            cent_sub  = REM1_W'(DAYS_100Y);
        end
        else
        begin
            cent_next = 2'd0;
            cent_sub  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            st1_era5_reg <= st0_era5_reg;
            st1_cent_reg <= cent_next;
            st1_rem_reg  <= 16'(st0_rem_reg - cent_sub);
        end
    end

    // stage 2: estimate of the 4-year period by reciprocal (q or q-1)
    logic [26:0] quad_prod;
    logic        st2_era5_reg;
    logic [1:0]  st2_cent_reg;
    logic [15:0] st2_rem_reg;
    logic [4:0]  st2_q_reg;

    assign quad_prod = 27'(st1_rem_reg) * 27'(QUAD_RECIP);

    always_ff @(posedge clk)
    begin
        if (stage_en[2])
        begin
            st2_era5_reg <= st1_era5_reg;
            st2_cent_reg <= st1_cent_reg;
            st2_rem_reg  <= st1_rem_reg;
            st2_q_reg    <= 5'(quad_prod >> QUAD_SHIFT);
        end
    end

    // stage 3: remainder of the estimate, below two periods
    logic [15:0] quad_rem;
    logic        st3_era5_reg;
    logic [1:0]  st3_cent_reg;
    logic [4:0]  st3_q_reg;
    logic [11:0] st3_rem_reg;

    assign quad_rem = st2_rem_reg - 16'(st2_q_reg) * 16'(DAYS_4Y);

    always_ff @(posedge clk)
    begin
        if (stage_en[3])
        begin
            st3_era5_reg <= st2_era5_reg;
            st3_cent_reg <= st2_cent_reg;
            st3_q_reg    <= st2_q_reg;
            st3_rem_reg  <= 12'(quad_rem);
        end
    end

    // stage 4: correct the estimate by one period
    logic        fix_quad;
    logic        st4_era5_reg;
    logic [1:0]  st4_cent_reg;
    logic [4:0]  st4_quad_reg;
    logic [10:0] st4_rem_reg;

    assign fix_quad = (st3_rem_reg >= 12'(DAYS_4Y));

    always_ff @(posedge clk)
    begin
        if (stage_en[4])
        begin
            st4_era5_reg <= st3_era5_reg;
            st4_cent_reg <= st3_cent_reg;
            if (fix_quad)
            begin
                st4_quad_reg <= st3_q_reg + 5'd1;
                st4_rem_reg  <= 11'(st3_rem_reg - 12'(DAYS_4Y));
            end
            else
            begin
                st4_quad_reg <= st3_q_reg;
                st4_rem_reg  <= 11'(st3_rem_reg);
            end
        end
    end

    // stage 5: year within the 4-year period, leap day clamps to year 3
    logic [1:0]  yr_next;
    logic [10:0] yr_sub;
    logic        st5_era5_reg;
    logic [1:0]  st5_cent_reg;
    logic [4:0]  st5_quad_reg;
    logic [1:0]  st5_yr_reg;
    logic [8:0]  st5_rem_reg;

    always_comb
    begin
        priority if (st4_rem_reg >= 11'(3 * DAYS_1Y))
        begin
            yr_next = 2'd3;
            yr_sub  = 11'(3 * DAYS_1Y);
        end
        else if (st4_rem_reg >= 11'(2 * DAYS_1Y))
        begin
            yr_next = 2'd2;
            yr_sub  = 11'(2 * DAYS_1Y);
        end
        else if (st4_rem_reg >= 11'(DAYS_1Y))
        begin
            yr_next = 2'd1;
            yr_sub  = 11'(DAYS_1Y);
        end
        else
        begin
            yr_next = 2'd0;
            yr_sub  = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[5])
        begin
            st5_era5_reg <= st4_era5_reg;
            st5_cent_reg <= st4_cent_reg;
            st5_quad_reg <= st4_quad_reg;
            st5_yr_reg   <= yr_next;
            st5_rem_reg  <= 9'(st4_rem_reg - yr_sub);
        end
    end

    // stage 6: month search, day of month and full year
    logic [3:0]  mi;
    logic [3:0]  month_next;
    logic [4:0]  mday_next;
    logic [11:0] year_next;
    logic [11:0] st6_year_reg;
    logic [3:0]  st6_month_reg;
    logic [4:0]  st6_mday_reg;

    always_comb
    begin
        mi = 4'd0;
        for (int i = 1; i < 12; i++)
        begin
            if (st5_rem_reg >= MARCH_MONTH_START[i])
            begin
                mi = 4'(i);
            end
        end
        // January and February belong to the next calendar year
        if (mi >= 4'd10)
        begin
            month_next = mi - 4'd9;
        end
        else
        begin
            month_next = mi + 4'd3;
        end
        mday_next = 5'(st5_rem_reg - MARCH_MONTH_START[mi]) + 5'd1;
        year_next = 12'(ERA4_YEAR)
                  + (st5_era5_reg ? 12'd400 : 12'd0)
                  + 12'(st5_cent_reg) * 12'd100
                  + {5'd0, st5_quad_reg, 2'b00}
                  + 12'(st5_yr_reg)
                  + ((mi >= 4'd10) ? 12'd1 : 12'd0);
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[6])
        begin
            st6_year_reg  <= year_next;
            st6_month_reg <= month_next;
            st6_mday_reg  <= mday_next;
        end
    end

    // stage 7: FAT range check and packing into the output register
    logic [WORD_W-1:0] date_next;
    logic              flag_next;
    logic [11:0]       year_ofs;
    logic [WORD_W-1:0] date_reg;
    logic              flag_reg;

    assign year_ofs = st6_year_reg - 12'(FAT_BASE_YEAR);

    always_comb
    begin
        priority if (st6_year_reg < 12'(FAT_BASE_YEAR))
        begin
            date_next = DATE_LOW_LIMIT;
            flag_next = 1'b1;
        end
        else if (st6_year_reg > 12'(FAT_LAST_YEAR))
        begin
            date_next = DATE_HIGH_LIMIT;
            flag_next = 1'b1;
        end
        else
        begin
            date_next = {year_ofs[6:0], st6_month_reg, st6_mday_reg};
            flag_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[7])
        begin
            date_reg <= date_next;
            flag_reg <= flag_next;
        end
    end

    assign packed_date = date_reg;
    assign range_flag  = flag_reg;

endmodule

### hw/rtl/day_count_to_fat_date.sv
`timescale 1ns / 1ps
// ============================================================================
// day_count_to_fat_date
// Converts a day/minute/tick timestamp into FAT date and time words.
// ============================================================================
// Usage: one beat in, one beat out, in order. The block is an eight-stage
// pipeline that takes a beat every cycle unless all stages are full and the
// output stalls; a beat enters stage 0 and moves stage by stage to the output
// register. Each stage holds while the one after it is full and stalled, and
// empty stages fill up, so s_tready stays high whenever any stage has room.
// The date path sets the depth: the 400-year period, the century, a reciprocal
// multiply for the 4-year period, its remainder, its correction, the year, the
// month search and the final packing each take one stage. Dates before
// 1980-01-01 or after 2107-12-31 come out clamped to those days with m_tuser set.
module day_count_to_fat_date
    import dcfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // s_tdata: [15:0] day_count, [26:16] minute_of_day,
    //          [38:27] tick_of_minute, [39] zero
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // m_tdata: [15:0] packed_date, [31:16] packed_time
    // m_tuser: [0] range_flag
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser
);

    // input fields
    logic [DAY_W-1:0]  day_count;
    logic [MIN_W-1:0]  minute_of_day;
    logic [TICK_W-1:0] tick_of_minute;

    assign day_count      = s_tdata[15:0];
    assign minute_of_day  = s_tdata[26:16];
    assign tick_of_minute = s_tdata[38:27];

    // stage control: a stage loads when empty or when the next one moves
    logic [STAGE_CNT-1:0] valid_reg;
    logic [STAGE_CNT-1:0] valid_next;
    logic [STAGE_CNT-1:0] stage_en;

    always_comb
    begin
        stage_en[STAGE_CNT-1] = !valid_reg[STAGE_CNT-1] || m_tready;
        for (int k = STAGE_CNT - 2; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
        valid_next[0] = stage_en[0] ? s_tvalid : valid_reg[0];
        for (int k = 1; k < STAGE_CNT; k++)
        begin
            valid_next[k] = stage_en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[STAGE_CNT-1];

    // time stage 0: clamp minutes, hours by reciprocal, seconds from ticks
    logic [MIN_W-1:0]       mins_clamp;
    logic [21:0]            hour_prod;
    logic [TICK_PROD_W-1:0] tick_prod;
    logic [TICK_W-1:0]      secs_full;
    logic [5:0]             secs_clamp;
    logic [MIN_W-1:0]       t0_mins_reg;
    logic [4:0]             t0_hours_reg;
    logic [4:0]             t0_half_reg;

    always_comb
    begin
        if (minute_of_day > MIN_W'(MAX_MINUTE))
        begin
            mins_clamp = MIN_W'(MAX_MINUTE);
        end
        else
        begin
            mins_clamp = minute_of_day;
        end
        hour_prod = 22'(mins_clamp) * 22'(HOUR_RECIP);
        tick_prod = TICK_PROD_W'(tick_of_minute) * TICK_PROD_W'(TICK_RECIP);
        secs_full = TICK_W'(tick_prod >> TICK_SHIFT);
        if (secs_full > TICK_W'(MAX_SECOND))
        begin
            secs_clamp = 6'(MAX_SECOND);
        end
        else
        begin
            secs_clamp = 6'(secs_full);
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            t0_mins_reg  <= mins_clamp;
            t0_hours_reg <= 5'(hour_prod >> HOUR_SHIFT);
            t0_half_reg  <= secs_clamp[5:1];
        end
    end

    // time stage 1: minute within the hour and the packed word
    logic [MIN_W-1:0]  minute_full;
    logic [WORD_W-1:0] time_pipe_reg [1:STAGE_CNT-1];

    assign minute_full = t0_mins_reg - MIN_W'(t0_hours_reg) * MIN_W'(60);

    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            time_pipe_reg[1] <= {t0_hours_reg, minute_full[5:0], t0_half_reg};
        end
    end

    // time word rides along with the date stages
    for (genvar k = 2; k < STAGE_CNT; k++)
    begin : g_time_delay
        always_ff @(posedge clk)
        begin
            if (stage_en[k])
            begin
                time_pipe_reg[k] <= time_pipe_reg[k-1];
            end
        end
    end

    // date path
    logic [WORD_W-1:0] packed_date;
    logic              range_flag;

    dcfd_civil u_civil (
        .clk         (clk),
        .stage_en    (stage_en),
        .day_count   (day_count),
        .packed_date (packed_date),
        .range_flag  (range_flag)
    );

    assign m_tdata = {time_pipe_reg[STAGE_CNT-1], packed_date};
    assign m_tuser = range_flag;

    // an empty output register means the whole pipeline can take a beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register empty");

    // a clamped date is exactly one of the two limit words
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |->
            (m_tdata[15:0] == DATE_LOW_LIMIT || m_tdata[15:0] == DATE_HIGH_LIMIT))
        else $error("range flag with non-limit date");

    // time fields stay within a day
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[31:27] <= 5'd23 && m_tdata[26:21] <= 6'd59
                      && m_tdata[20:16] <= 5'd29))
        else $error("time field out of range");

    // an in-range date has a real month and day
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |->
            (m_tdata[8:5] >= 4'd1 && m_tdata[8:5] <= 4'd12 && m_tdata[4:0] != 5'd0))
        else $error("date field out of range");

endmodule

### dv/fat_stamp_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fat_stamp_checker
// Watches both stream ports of the day-count to FAT date/time converter.
// Each accepted input beat yields the predicted date word, time word and
// range flag. Each output beat is compared with the oldest prediction.
// ============================================================================
module fat_stamp_checker
    import dcfd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    input  logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   m_tuser,
    output int unsigned            fail_count,
    output int unsigned            stamps_pending,
    output int unsigned            stamps_checked,
    output int unsigned            dates_clamped
);

    // Days from 1 March of year 0 to 1 January 1978
    localparam int unsigned EPOCH_OFFSET = 722390;
    localparam int unsigned ERA_DAYS     = 146097;
    localparam int unsigned CENT_DAYS    = 36524;
    localparam int unsigned QUAD_DAYS    = 1461;
    localparam int unsigned YEAR_DAYS    = 365;
    localparam int unsigned YEAR_FIRST   = 1980;
    localparam int unsigned YEAR_LAST    = 2107;
    localparam logic [15:0] DATE_FLOOR   = 16'h0021;
    localparam logic [15:0] DATE_CEIL    = 16'hFF9F;

    // Day offset of each month start, year counted from 1 March
    localparam int unsigned MONTH_START [12] = '{
        0, 31, 61, 92, 122, 153, 184, 214, 245, 275, 306, 337
    };

    typedef struct packed {
        logic [15:0] packed_date;
        logic [15:0] packed_time;
        logic        range_flag;
    } fat_stamp_t;

    fat_stamp_t expected_stamps [$];

    initial
    begin
        fail_count     = 0;
        stamps_pending = 0;
        stamps_checked = 0;
        dates_clamped  = 0;
    end

    // Civil date by staged division, then FAT packing with clamping
    function automatic fat_stamp_t predict_fat_stamp(input logic [15:0] day,
                                                     input logic [10:0] minute,
                                                     input logic [11:0] tick);
        int unsigned z, era, rem, cent, quad, yr, mi;
        int unsigned year, month, mday, mins, secs;
        fat_stamp_t  stamp;
        mins = (minute > 11'd1439) ? 1439 : minute;
        secs = tick / TICKS_PER_SEC;
        if (secs > 59)
            secs = 59;
        stamp.packed_time = {5'((mins / 60)), 6'((mins % 60)), 5'((secs / 2))};

        z    = day + EPOCH_OFFSET;
        era  = z / ERA_DAYS;
        rem  = z - era * ERA_DAYS;
        cent = rem / CENT_DAYS;
        if (cent > 3)
            cent = 3;   // last day of a 400-year era
        rem  = rem - cent * CENT_DAYS;
        quad = rem / QUAD_DAYS;
        rem  = rem - quad * QUAD_DAYS;
        yr   = rem / YEAR_DAYS;
        if (yr > 3)
            yr = 3;     // leap day closing a 4-year period
        rem  = rem - yr * YEAR_DAYS;
        mi   = 11;
        while (mi > 0 && rem < MONTH_START[mi])
            mi--;
        year  = era * 400 + cent * 100 + quad * 4 + yr;
        month = mi + 3;
        if (month > 12)
        begin
            month = month - 12;
            year  = year + 1;
        end
        mday = rem - MONTH_START[mi] + 1;

        stamp.range_flag = 1'b1;
        if (year < YEAR_FIRST)
            stamp.packed_date = DATE_FLOOR;
        else if (year > YEAR_LAST)
            stamp.packed_date = DATE_CEIL;
        else
        begin
            stamp.packed_date = {7'((year - YEAR_FIRST)), 4'(month), 5'(mday)};
            stamp.range_flag  = 1'b0;
        end
        return stamp;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("[%0t] MISMATCH %s: got 0x%04h, expected 0x%04h", $time, what, got, want);
        fail_count++;
    endtask

    // Retire output beats first, then record the input beat of the same edge
    always @(posedge clk or negedge rst_n)
    begin
        fat_stamp_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_stamps.size() == 0)
                begin
                    report_mismatch("output beat with nothing expected", m_tdata[15:0], 16'h0);
                end
                else
                begin
                    want = expected_stamps.pop_front();
                    stamps_checked++;
                    if (want.range_flag)
                        dates_clamped++;
                    if (m_tdata[15:0] !== want.packed_date)
                        report_mismatch("packed_date", m_tdata[15:0], want.packed_date);
                    if (m_tdata[31:16] !== want.packed_time)
                        report_mismatch("packed_time", m_tdata[31:16], want.packed_time);
                    if (m_tuser !== want.range_flag)
                        report_mismatch("range_flag", {15'h0, m_tuser}, {15'h0, want.range_flag});
                end
            end
            if (s_tvalid && s_tready)
                expected_stamps.push_back(predict_fat_stamp(s_tdata[15:0], s_tdata[26:16],
                                                            s_tdata[38:27]));
            stamps_pending = expected_stamps.size();
        end
    end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Stream stimulus for the day-count to FAT date/time converter.
// Directed beats hit the clamp limits, leap days and out-of-range minutes and
// ticks. Random beats follow under four idle/stall mixes, and a separate
// checker compares every output beat.
// ============================================================================
module testbench;
    import dcfd_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PHASE_STAMPS  = 375;

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    int unsigned fail_count;
    int unsigned stamps_pending;
    int unsigned stamps_checked;
    int unsigned dates_clamped;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    day_count_to_fat_date dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    fat_stamp_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .stamps_pending (stamps_pending),
        .stamps_checked (stamps_checked),
        .dates_clamped  (dates_clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver backpressure, redrawn every cycle
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d beats still expected",
                     cycle_count, stamps_pending);
            $display("Verification failed");
            $finish;
        end
    end

    // One input beat; called and returning at a falling edge
    task automatic send_stamp(input logic [15:0] day, input logic [10:0] minute,
                              input logic [11:0] tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, tick, minute, day};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // Mostly in-range fields, with the full field widths mixed in
    task automatic send_random_stamp();
        logic [15:0] day;
        logic [10:0] minute;
        logic [11:0] tick;
        case ($urandom_range(9))
            0:       day = 16'($urandom_range(65535));
            1:       day = 16'($urandom_range(729));
            2:       day = 16'($urandom_range(65535, 47481));
            default: day = 16'($urandom_range(47480, 730));
        endcase
        minute = ($urandom_range(7) == 0) ? 11'($urandom_range(2047, 1440))
                                          : 11'($urandom_range(1439));
        tick   = ($urandom_range(7) == 0) ? 12'($urandom_range(4095, 3000))
                                          : 12'($urandom_range(2999));
        send_stamp(day, minute, tick);
    endtask

    task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (PHASE_STAMPS)
            send_random_stamp();
        s_tvalid <= 1'b0;
        // let the pipeline drain before the next mix
        wait (stamps_pending == 0);
        @(negedge clk);
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: clamp edges, leap days, century rule, field extremes
        send_stamp(16'd0,     11'd0,    12'd0);
        send_stamp(16'd729,   11'd1439, 12'd2999);
        send_stamp(16'd730,   11'd1440, 12'd3000);
        send_stamp(16'd789,   11'd2047, 12'd4095);   // 1980-02-29
        send_stamp(16'd1095,  11'd59,   12'd49);     // 1980-12-31
        send_stamp(16'd8093,  11'd60,   12'd50);     // 2000-02-28
        send_stamp(16'd8094,  11'd61,   12'd99);     // 2000-02-29
        send_stamp(16'd8095,  11'd719,  12'd100);    // 2000-03-01
        send_stamp(16'd44618, 11'd720,  12'd149);    // 2100-02-28
        send_stamp(16'd44619, 11'd1380, 12'd2950);   // 2100-03-01, no leap day
        send_stamp(16'd47480, 11'd1439, 12'd2949);   // 2107-12-31
        send_stamp(16'd47481, 11'd0,    12'd2999);
        send_stamp(16'd65535, 11'd1024, 12'd2048);
        send_stamp(16'h5555,  11'h555,  12'h555);
        send_stamp(16'hAAAA,  11'h2AA,  12'hAAA);
        send_stamp(16'd32768, 11'd1023, 12'd2047);
        s_tvalid <= 1'b0;
        wait (stamps_pending == 0);
        @(negedge clk);

        // Random: free flow, sender gaps, receiver stalls, both
        run_phase(0, 0);
        run_phase(47, 0);
        run_phase(0, 47);
        run_phase(34, 34);

        wait (stamps_pending == 0);
        repeat (STAGE_CNT + 8) @(posedge clk);

        $display("Checked %0d timestamp beats, %0d with a clamped date, in %0d cycles",
                 stamps_checked, dates_clamped, cycle_count);
        $display("Mixes: free flow, sender gaps, receiver stalls and both; %0d mismatches",
                 fail_count);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/dcfd_pkg.sv
hw/rtl/dcfd_civil.sv
hw/rtl/day_count_to_fat_date.sv
dv/fat_stamp_checker.sv
dv/testbench.sv
